// File: rtl/core/gaes_pkg.sv
`default_nettype none

package gaes_pkg;

    // Default string capacity
    localparam int MAX_LEN_DEF = 64;

    // Fixed field widths
    localparam int MODE_W    = 2;
    localparam int SYMBOL_W  = 8;
    localparam int COST_W    = 8;
    localparam int SCORE_W   = 16;
    localparam int CFG_IDX_W = 2;

    // Register reset values
    localparam logic signed [COST_W-1:0] GAP_RST      = 8'sd2;
    localparam logic signed [COST_W-1:0] MATCH_RST    = 8'sd0;
    localparam logic signed [COST_W-1:0] MISMATCH_RST = 8'sd1;

    typedef enum logic [MODE_W-1:0] {
        MODE_APPEND_A = 2'd0,
        MODE_APPEND_B = 2'd1,
        MODE_COMPUTE  = 2'd2
    } t_mode;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GAP      = 2'd0,
        CFG_MATCH    = 2'd1,
        CFG_MISMATCH = 2'd2
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROW,
        ST_UP,
        ST_LEFT,
        ST_DIAG,
        ST_DONE
    } t_state;

endpackage

`default_nettype wire

// File: rtl/core/gaes_in_if.sv
`default_nettype none

interface gaes_in_if;
    import gaes_pkg::*;

    logic                valid;
    logic                ready;
    logic [MODE_W-1:0]   mode;
    logic [SYMBOL_W-1:0] symbol;

    modport source (output valid, output mode, output symbol, input ready);
    modport sink   (input valid, input mode, input symbol, output ready);
endinterface

`default_nettype wire

// File: rtl/core/gaes_out_if.sv
`default_nettype none

interface gaes_out_if;
    import gaes_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [SCORE_W-1:0] score;
    logic                      overflow;

    modport source (output valid, output score, output overflow, input ready);
    modport sink   (input valid, input score, input overflow, output ready);
endinterface

`default_nettype wire

// File: rtl/core/gaes_alu.sv
`default_nettype none

// Shared add-and-compare unit: res = load ? a + c : min(a + c, b)
module gaes_alu #(
    parameter int CW = 17
) (
    input  logic signed [CW-1:0]                i_a,
    input  logic signed [gaes_pkg::COST_W-1:0] i_c,
    input  logic signed [CW-1:0]                i_b,
    input  logic                                i_load,
    output logic signed [CW-1:0]                o_res
);
    import gaes_pkg::*;

    logic signed [CW-1:0] sum;

    // Add the cost, then keep the smaller of the sum and the running minimum
    always_comb begin
        sum = i_a + CW'(i_c);
        if (i_load || (sum < i_b)) begin
            o_res = sum;
        end else begin
            o_res = i_b;
        end
    end
endmodule

`default_nettype wire

// File: rtl/core/global_alignment_edit_score_unit.sv
`default_nettype none

// Channel  Dir  Payload                      Transfer
// i_in     in   mode[1:0], symbol[7:0]       i_in.valid & i_in.ready
// o_out    out  score[15:0] s, overflow      o_out.valid & o_out.ready
// i_cfg    in   i_cfg_idx[1:0], i_cfg_data   i_cfg_we
//
// An append item is accepted while idle. A compute item sweeps an n-by-m matrix for
// strings of length n and m (going straight to the result if either is empty): every cell makes
// three passes through the one shared add/compare unit, and each row starts with a state that
// fetches the row symbol. i_in.ready is high only while the sequencer is idle.
// A result waits in the output register; the next compute holds in its last state
// until that register is free. Reset (synchronous, active low) empties both strings.
module global_alignment_edit_score_unit #(
    parameter int MAX_LEN = gaes_pkg::MAX_LEN_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    gaes_in_if.sink                              i_in,
    gaes_out_if.source                           o_out,
    input  logic                                 i_cfg_we,
    input  logic [gaes_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [gaes_pkg::COST_W-1:0]          i_cfg_data
);
    import gaes_pkg::*;

    localparam int LW = $clog2(MAX_LEN + 1);
    localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int CW = $clog2(256 * MAX_LEN + 256) + 2;
    localparam int SMAX = 2 ** (SCORE_W - 1) - 1;
    localparam int SMIN = -(2 ** (SCORE_W - 1));

    // Cost registers
    logic signed [COST_W-1:0] r_gap;
    logic signed [COST_W-1:0] r_match;
    logic signed [COST_W-1:0] r_mismatch;

    // Sequencer
    t_state r_state;
    t_state n_state;

    // String stores and lengths
    logic [SYMBOL_W-1:0] mem_a [MAX_LEN];
    logic [SYMBOL_W-1:0] mem_b [MAX_LEN];
    logic signed [CW-1:0] mem_row [MAX_LEN];
    logic [LW-1:0] r_len_a;
    logic [LW-1:0] r_len_b;
    logic          r_dropped;

    // Registered read data
    logic [SYMBOL_W-1:0]  r_a_q;
    logic [SYMBOL_W-1:0]  r_b_q;
    logic signed [CW-1:0] r_row_q;

    // Sweep state
    logic [LW-1:0]        r_i;
    logic [LW-1:0]        r_j;
    logic signed [CW-1:0] r_left;
    logic signed [CW-1:0] r_diag;
    logic signed [CW-1:0] r_acc;

    // Output register
    logic                      r_out_valid;
    logic signed [SCORE_W-1:0] r_score;
    logic                      r_ovf;

    // Control
    logic                 in_xfer;
    t_mode                in_mode;
    logic                 out_load;
    logic                 row_end;
    logic                 last_row;
    logic                 a_rd;
    logic                 bj_rd;
    logic [AW-1:0]        bj_addr;
    logic [AW-1:0]        a_addr;
    logic [AW-1:0]        wr_addr;
    logic [LW-1:0]        i_m1;
    logic [LW-1:0]        j_m1;
    logic                 row_we;
    logic signed [CW-1:0] up_val;
    logic signed [COST_W-1:0] subst_cost;
    logic signed [CW-1:0] alu_a;
    logic signed [COST_W-1:0] alu_c;
    logic                 alu_load;
    logic signed [CW-1:0] alu_res;
    logic signed [SCORE_W-1:0] sat_score;

    assign in_xfer  = i_in.valid && i_in.ready;
    assign in_mode  = t_mode'(i_in.mode);
    assign out_load = (r_state == ST_DONE) && (!r_out_valid || o_out.ready);
    assign row_end  = (r_j == r_len_b);
    assign last_row = (r_i == r_len_a);
    assign i_m1     = r_i - LW'(1);
    assign j_m1     = r_j - LW'(1);
    assign a_addr   = i_m1[AW-1:0];
    assign wr_addr  = j_m1[AW-1:0];

    assign i_in.ready     = (r_state == ST_IDLE);
    assign o_out.valid    = r_out_valid;
    assign o_out.score    = r_score;
    assign o_out.overflow = r_ovf;

    // Cell above: first row holds its column index
    assign up_val     = (r_i == LW'(1)) ? $signed({{(CW - LW){1'b0}}, r_j}) : r_row_q;
    assign subst_cost = (r_a_q == r_b_q) ? r_match : r_mismatch;

    // Write cost registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gap      <= GAP_RST;
            r_match    <= MATCH_RST;
            r_mismatch <= MISMATCH_RST;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_GAP:      r_gap      <= i_cfg_data;
                CFG_MATCH:    r_match    <= i_cfg_data;
                CFG_MISMATCH: r_mismatch <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Advance sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_xfer && (in_mode == MODE_COMPUTE)) begin
                    if ((r_len_a == '0) || (r_len_b == '0)) begin
                        n_state = ST_DONE;
                    end else begin
                        n_state = ST_ROW;
                    end
                end
            end
            ST_ROW:  n_state = ST_UP;
            ST_UP:   n_state = ST_LEFT;
            ST_LEFT: n_state = ST_DIAG;
            ST_DIAG: begin
                if (!row_end) begin
                    n_state = ST_UP;
                end else if (last_row) begin
                    n_state = ST_DONE;
                end else begin
                    n_state = ST_ROW;
                end
            end
            ST_DONE: begin
                if (out_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Sequencer outputs: memory reads, row write, unit operands
    always_comb begin
        a_rd     = 1'b0;
        bj_rd    = 1'b0;
        bj_addr  = '0;
        row_we   = 1'b0;
        alu_a    = r_acc;
        alu_c    = r_gap;
        alu_load = 1'b0;
        case (r_state)
            ST_ROW: begin
                a_rd  = 1'b1;
                bj_rd = 1'b1;
            end
            ST_UP: begin
                alu_a    = up_val;
                alu_load = 1'b1;
            end
            ST_LEFT: begin
                alu_a = r_left;
            end
            ST_DIAG: begin
                alu_a   = r_diag;
                alu_c   = subst_cost;
                row_we  = 1'b1;
                bj_rd   = !row_end;
                bj_addr = r_j[AW-1:0];
            end
            default: ;
        endcase
    end

    gaes_alu #(
        .CW (CW)
    ) u_alu (
        .i_a    (alu_a),
        .i_c    (alu_c),
        .i_b    (r_acc),
        .i_load (alu_load),
        .o_res  (alu_res)
    );

    // String stores: append write, registered read
    always_ff @(posedge i_clk) begin
        if (in_xfer && (in_mode == MODE_APPEND_A) && (r_len_a != LW'(MAX_LEN))) begin
            mem_a[r_len_a[AW-1:0]] <= i_in.symbol;
        end
        if (a_rd) begin
            r_a_q <= mem_a[a_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer && (in_mode == MODE_APPEND_B) && (r_len_b != LW'(MAX_LEN))) begin
            mem_b[r_len_b[AW-1:0]] <= i_in.symbol;
        end
        if (bj_rd) begin
            r_b_q <= mem_b[bj_addr];
        end
    end

    // Score row store
    always_ff @(posedge i_clk) begin
        if (row_we) begin
            mem_row[wr_addr] <= alu_res;
        end
        if (bj_rd) begin
            r_row_q <= mem_row[bj_addr];
        end
    end

    // Lengths and dropped flag; clear after a compute
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len_a   <= '0;
            r_len_b   <= '0;
            r_dropped <= 1'b0;
        end else if (out_load) begin
            r_len_a   <= '0;
            r_len_b   <= '0;
            r_dropped <= 1'b0;
        end else if (in_xfer) begin
            case (in_mode)
                MODE_APPEND_A: begin
                    if (r_len_a != LW'(MAX_LEN)) begin
                        r_len_a <= r_len_a + LW'(1);
                    end else begin
                        r_dropped <= 1'b1;
                    end
                end
                MODE_APPEND_B: begin
                    if (r_len_b != LW'(MAX_LEN)) begin
                        r_len_b <= r_len_b + LW'(1);
                    end else begin
                        r_dropped <= 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    // Row and column counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_i <= '0;
            r_j <= '0;
        end else begin
            case (r_state)
                ST_IDLE: r_i <= LW'(1);
                ST_ROW:  r_j <= LW'(1);
                ST_DIAG: begin
                    if (!row_end) begin
                        r_j <= r_j + LW'(1);
                    end else if (!last_row) begin
                        r_i <= r_i + LW'(1);
                    end
                end
                default: ;
            endcase
        end
    end

    // Cell datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: r_acc <= '0;
            ST_ROW: begin
                r_left <= $signed({{(CW - LW){1'b0}}, r_i});
                r_diag <= $signed({{(CW - LW){1'b0}}, i_m1});
            end
            ST_UP:   r_acc <= alu_res;
            ST_LEFT: r_acc <= alu_res;
            ST_DIAG: begin
                r_acc  <= alu_res;
                r_left <= alu_res;
                r_diag <= up_val;
            end
            default: ;
        endcase
    end

    // Saturate final cell to the score range
    always_comb begin
        if (r_acc > SMAX) begin
            sat_score = SCORE_W'(SMAX);
        end else if (r_acc < SMIN) begin
            sat_score = SCORE_W'(SMIN);
        end else begin
            sat_score = SCORE_W'(r_acc);
        end
    end

    // Output register: hold until transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_score <= sat_score;
            r_ovf   <= r_dropped;
        end
    end

    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_len_a <= LW'(MAX_LEN)) && (r_len_b <= LW'(MAX_LEN)))
        else $error("string length beyond capacity");

    a_row_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ROW) |-> ((r_i >= LW'(1)) && (r_i <= r_len_a)))
        else $error("row counter out of range");

    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_UP) |-> ((r_j >= LW'(1)) && (r_j <= r_len_b)))
        else $error("column counter out of range");

    a_out_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == ST_DONE))
        else $error("result loaded outside completion");

    a_clear_after: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |=> ((r_len_a == '0) && (r_len_b == '0) && !r_dropped))
        else $error("stores not cleared after compute");

endmodule

`default_nettype wire
